FILE: src/chm_pkg.sv
// Shared types and constants for the chained hash map core.
package chm_pkg;

  localparam int KEY_W       = 64;
  localparam int SIZE_W      = 32;
  localparam int REC_W       = SIZE_W + 2;
  localparam int BC_W        = 9;
  localparam logic [BC_W-1:0] BC_RESET = 9'd256;

  // Bucket hash: bits of the key consumed per cycle by the remainder unit.
  localparam int HASH_STEP_BITS = 4;
  localparam int HASH_CYCLES    = KEY_W / HASH_STEP_BITS;
  localparam int HASH_CNT_W     = $clog2(HASH_CYCLES);

  typedef enum logic [1:0] {
    CMD_SET   = 2'd0,
    CMD_GET   = 2'd1,
    CMD_ERASE = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [KEY_W-1:0]  key;
    logic [SIZE_W-1:0] in_size;
    logic              in_marked;
    logic              in_scan;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [SIZE_W-1:0] out_size;
    logic              out_marked;
    logic              out_scan;
  } out_item_t;

  // Controller -> datapath commands.
  typedef struct packed {
    logic    load_in;
    logic    hash_step;
    logic    head_rd;
    logic    head_load;
    logic    node_rd;
    logic    node_adv;
    logic    rec_wr;
    logic    alloc_rd;
    logic    alloc_free;
    logic    alloc_fresh;
    logic    node_init_wr;
    logic    link_append;
    logic    erase_unlink;
    logic    erase_free;
    logic    clear_step;
    logic    res_load;
    logic    res_hit;
    status_e res_status;
  } ctrl_cmd_t;

  // Datapath -> controller status.
  typedef struct packed {
    cmd_e cmd;
    logic hash_last;
    logic cur_nil;
    logic key_match;
    logic free_avail;
    logic fresh_avail;
    logic clear_last;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: src/chm_ctrl.sv
// Controller state machine for the chained hash map core.
module chm_ctrl import chm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [12:0] {
    S_CLEAR      = 13'b0000000000001,
    S_IDLE       = 13'b0000000000010,
    S_HASH       = 13'b0000000000100,
    S_HEAD_RD    = 13'b0000000001000,
    S_HEAD_WT    = 13'b0000000010000,
    S_NODE_RD    = 13'b0000000100000,
    S_NODE_CMP   = 13'b0000001000000,
    S_ALLOC_RD   = 13'b0000010000000,
    S_ALLOC_WT   = 13'b0000100000000,
    S_NODE_WR    = 13'b0001000000000,
    S_LINK_WR    = 13'b0010000000000,
    S_ERASE_FREE = 13'b0100000000000,
    S_RESP       = 13'b1000000000000
  } state_t;

  state_t  state_r, state_nxt;
  status_e status_r, status_nxt;
  logic    hit_r, hit_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    hit_nxt    = hit_r;
    cmd        = '0;
    cmd.res_status = status_r;
    cmd.res_hit    = hit_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          status_nxt  = ST_OK;
          hit_nxt     = 1'b0;
          state_nxt   = S_HASH;
        end
      end
      S_HASH: begin
        if (stat.cmd == CMD_NOP) begin
          state_nxt = S_RESP;
        end else begin
          cmd.hash_step = 1'b1;
          if (stat.hash_last) state_nxt = S_HEAD_RD;
        end
      end
      S_HEAD_RD: begin
        cmd.head_rd = 1'b1;
        state_nxt   = S_HEAD_WT;
      end
      S_HEAD_WT: begin
        cmd.head_load = 1'b1;
        state_nxt     = S_NODE_RD;
      end
      S_NODE_RD: begin
        if (!stat.cur_nil) begin
          cmd.node_rd = 1'b1;
          state_nxt   = S_NODE_CMP;
        end else if (stat.cmd != CMD_SET) begin
          status_nxt = ST_MISS;
          state_nxt  = S_RESP;
        end else if (stat.free_avail) begin
          state_nxt = S_ALLOC_RD;
        end else if (stat.fresh_avail) begin
          cmd.alloc_fresh = 1'b1;
          state_nxt       = S_NODE_WR;
        end else begin
          status_nxt = ST_FULL;
          state_nxt  = S_RESP;
        end
      end
      S_NODE_CMP: begin
        if (!stat.key_match) begin
          cmd.node_adv = 1'b1;
          state_nxt    = S_NODE_RD;
        end else if (stat.cmd == CMD_SET) begin
          cmd.rec_wr = 1'b1;
          state_nxt  = S_RESP;
        end else if (stat.cmd == CMD_GET) begin
          hit_nxt   = 1'b1;
          state_nxt = S_RESP;
        end else begin
          cmd.erase_unlink = 1'b1;
          state_nxt        = S_ERASE_FREE;
        end
      end
      S_ALLOC_RD: begin
        cmd.alloc_rd = 1'b1;
        state_nxt    = S_ALLOC_WT;
      end
      S_ALLOC_WT: begin
        cmd.alloc_free = 1'b1;
        state_nxt      = S_NODE_WR;
      end
      S_NODE_WR: begin
        cmd.node_init_wr = 1'b1;
        state_nxt        = S_LINK_WR;
      end
      S_LINK_WR: begin
        cmd.link_append = 1'b1;
        state_nxt       = S_RESP;
      end
      S_ERASE_FREE: begin
        cmd.erase_free = 1'b1;
        state_nxt      = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLEAR;
      status_r <= ST_OK;
      hit_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      hit_r    <= hit_nxt;
    end
  end

endmodule

FILE: src/chm_datapath.sv
// Datapath of the chained hash map core: remainder unit, bucket and node memories.
module chm_datapath import chm_pkg::*; #(
  parameter int MAX_BUCKETS = 256,
  parameter int POOL_NODES  = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  in_item_t        in_data,
  input  logic            cfg_valid,
  input  logic [BC_W-1:0] cfg_data,
  input  logic            out_ready,
  output logic            out_valid,
  output out_item_t       out_data,
  input  ctrl_cmd_t       cmd,
  output dp_stat_t        stat
);

  localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int RW = BW + 1;
  localparam int NW = $clog2(POOL_NODES + 1);
  localparam int AW = $clog2(POOL_NODES);
  localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

  // Memories.
  logic [NW-1:0]    bucket_head_mem [MAX_BUCKETS];
  logic [KEY_W-1:0] node_key_mem    [POOL_NODES];
  logic [REC_W-1:0] node_rec_mem    [POOL_NODES];
  logic [NW-1:0]    node_link_mem   [POOL_NODES];

  logic [BC_W-1:0]       bucket_count_r;
  cmd_e                  cmd_q_r;
  logic [KEY_W-1:0]      key_q_r, key_sh_r;
  logic [REC_W-1:0]      rec_q_r;
  logic [BW-1:0]         rem_r, rem_nxt;
  logic [HASH_CNT_W-1:0] hcnt_r;
  logic [NW-1:0]         head_rd_r, cur_r, prev_r, alloc_r, free_head_r, fresh_r;
  logic [BW-1:0]         clr_cnt_r;
  logic [KEY_W-1:0]      key_rd_r;
  logic [REC_W-1:0]      rec_rd_r;
  logic [NW-1:0]         link_rd_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  logic [RW-1:0] bc_eff, hr;
  logic          prev_nil;

  // Effective bucket count: zero reads as one, clamp to the table size.
  always_comb begin
    if (bucket_count_r == '0) bc_eff = RW'(1);
    else if (32'(bucket_count_r) > 32'(MAX_BUCKETS)) bc_eff = RW'(MAX_BUCKETS);
    else bc_eff = RW'(bucket_count_r);
  end

  // Restoring remainder, HASH_STEP_BITS key bits per cycle, MSB first.
  always_comb begin
    hr = {1'b0, rem_r};
    for (int i = 0; i < HASH_STEP_BITS; i++) begin
      hr = {hr[BW-1:0], key_sh_r[KEY_W-1-i]};
      if (hr >= bc_eff) hr = hr - bc_eff;
    end
    rem_nxt = hr[BW-1:0];
  end

  assign prev_nil = (prev_r == NIL);

  // Bucket heads.
  logic          bh_we;
  logic [BW-1:0] bh_waddr;
  logic [NW-1:0] bh_wdata;

  always_comb begin
    bh_we    = cmd.clear_step | ((cmd.link_append | cmd.erase_unlink) & prev_nil);
    bh_waddr = cmd.clear_step ? clr_cnt_r : rem_r;
    if (cmd.clear_step) bh_wdata = NIL;
    else if (cmd.link_append) bh_wdata = alloc_r;
    else bh_wdata = link_rd_r;
  end

  always_ff @(posedge clk) begin
    if (bh_we) bucket_head_mem[bh_waddr] <= bh_wdata;
    if (cmd.head_rd) head_rd_r <= bucket_head_mem[rem_r];
  end

  // Node key and record.
  always_ff @(posedge clk) begin
    if (cmd.node_init_wr) node_key_mem[alloc_r[AW-1:0]] <= key_q_r;
    if (cmd.node_init_wr) node_rec_mem[alloc_r[AW-1:0]] <= rec_q_r;
    else if (cmd.rec_wr) node_rec_mem[cur_r[AW-1:0]] <= rec_q_r;
    if (cmd.node_rd) begin
      key_rd_r <= node_key_mem[cur_r[AW-1:0]];
      rec_rd_r <= node_rec_mem[cur_r[AW-1:0]];
    end
  end

  // Node links.
  logic          nl_we;
  logic [AW-1:0] nl_waddr, nl_raddr;
  logic [NW-1:0] nl_wdata;

  always_comb begin
    nl_we    = 1'b1;
    nl_waddr = cur_r[AW-1:0];
    nl_wdata = free_head_r;
    priority if (cmd.node_init_wr) begin
      nl_waddr = alloc_r[AW-1:0];
      nl_wdata = NIL;
    end else if (cmd.link_append && !prev_nil) begin
      nl_waddr = prev_r[AW-1:0];
      nl_wdata = alloc_r;
    end else if (cmd.erase_unlink && !prev_nil) begin
      nl_waddr = prev_r[AW-1:0];
      nl_wdata = link_rd_r;
    end else if (cmd.erase_free) begin
      nl_waddr = cur_r[AW-1:0];
      nl_wdata = free_head_r;
    end else begin
      nl_we = 1'b0;
    end
    nl_raddr = cmd.alloc_rd ? free_head_r[AW-1:0] : cur_r[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (nl_we) node_link_mem[nl_waddr] <= nl_wdata;
    if (cmd.node_rd || cmd.alloc_rd) link_rd_r <= node_link_mem[nl_raddr];
  end

  // Working registers without reset.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_q_r  <= in_data.cmd;
      key_q_r  <= in_data.key;
      key_sh_r <= in_data.key;
      rec_q_r  <= {in_data.in_scan, in_data.in_marked, in_data.in_size};
      rem_r    <= '0;
      hcnt_r   <= '0;
    end else if (cmd.hash_step) begin
      key_sh_r <= key_sh_r << HASH_STEP_BITS;
      rem_r    <= rem_nxt;
      hcnt_r   <= hcnt_r + 1'b1;
    end
    if (cmd.head_load) begin
      cur_r  <= head_rd_r;
      prev_r <= NIL;
    end else if (cmd.node_adv) begin
      prev_r <= cur_r;
      cur_r  <= link_rd_r;
    end
    if (cmd.alloc_fresh) alloc_r <= fresh_r;
    else if (cmd.alloc_free) alloc_r <= free_head_r;
    if (cmd.res_load) begin
      out_data_r.status     <= cmd.res_status;
      out_data_r.out_size   <= cmd.res_hit ? rec_rd_r[SIZE_W-1:0] : '0;
      out_data_r.out_marked <= cmd.res_hit & rec_rd_r[SIZE_W];
      out_data_r.out_scan   <= cmd.res_hit & rec_rd_r[SIZE_W+1];
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bucket_count_r <= BC_RESET;
      free_head_r    <= NIL;
      fresh_r        <= '0;
      clr_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid) bucket_count_r <= cfg_data;
      if (cmd.alloc_free) free_head_r <= link_rd_r;
      else if (cmd.erase_free) free_head_r <= cur_r;
      if (cmd.alloc_fresh) fresh_r <= fresh_r + 1'b1;
      if (cmd.clear_step) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (cmd.res_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    stat.cmd         = cmd_q_r;
    stat.hash_last   = (hcnt_r == HASH_CNT_W'(HASH_CYCLES - 1));
    stat.cur_nil     = (cur_r == NIL);
    stat.key_match   = (key_rd_r == key_q_r);
    stat.free_avail  = (free_head_r != NIL);
    stat.fresh_avail = (fresh_r != NIL);
    stat.clear_last  = (clr_cnt_r == BW'(MAX_BUCKETS - 1));
    stat.out_free    = !out_valid_r || out_ready;
  end

endmodule

FILE: src/chained_hash_map_core.sv
// Chained hash map core: top level joining controller and datapath.
//
// Separately chained hash table keyed by a 64-bit address. Each transaction
// on the input channel is one command (set, get or erase) and yields exactly
// one result transaction. The bucket is key mod bucket_count (cfg port; 0 is
// taken as 1, values above MAX_BUCKETS as MAX_BUCKETS), computed by a
// remainder unit that retires 4 key bits a cycle. Chains are walked one
// node per node-memory read. One command is in flight at a time; a finished
// result waits in the output register while the next command is accepted.
// After reset the bucket heads are cleared one per cycle, so in_ready stays
// low until every bucket head has been cleared. bucket_count writes are
// accepted at any time but should only be issued while the core is idle;
// changing it does not rehash existing entries.
module chained_hash_map_core import chm_pkg::*; #(
  parameter int MAX_BUCKETS = 256,
  parameter int POOL_NODES  = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  in_item_t        in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output out_item_t       out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [BC_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Config register always takes the write.
  assign cfg_ready = 1'b1;

  chm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  chm_datapath #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .POOL_NODES  (POOL_NODES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

FILE: src/chm_checker.sv
// Port-level checker for the chained hash map core, with its bind.
module chm_port_checker import chm_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input in_item_t        in_data,
  input logic            out_valid,
  input logic            out_ready,
  input out_item_t       out_data,
  input logic            cfg_valid,
  input logic            cfg_ready,
  input logic [BC_W-1:0] cfg_data
);

  // Clearing pass holds off commands right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_ready)
    else $error("in_ready high during bucket clearing");

  // One command at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second transaction accepted while busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 2'(out_data.status) != 2'd3)
    else $error("undefined status code");

  // Only a successful get carries record data; failures carry none.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.out_size == '0 && !out_data.out_marked && !out_data.out_scan)
    else $error("record data on a failed transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

endmodule

bind chained_hash_map_core chm_port_checker u_chm_checker (.*);

FILE: sim/chm_checker.sv
// Checker for the chained hash map core: shadow table, result compare.
`timescale 1ns / 100ps
module chm_checker import chm_pkg::*; #(
  parameter int MAX_BUCKETS = 256,
  parameter int POOL_NODES  = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_ready,
  input  in_item_t        in_data,
  input  logic            out_valid,
  input  logic            out_ready,
  input  out_item_t       out_data,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [BC_W-1:0] cfg_data,
  output int              fail_count,
  output int              pending
);

  localparam int NIL = POOL_NODES;

  int              head_tbl [MAX_BUCKETS];
  logic [KEY_W-1:0] key_tbl [POOL_NODES];
  logic [REC_W-1:0] rec_tbl [POOL_NODES];
  int              link_tbl [POOL_NODES];
  int              fresh_ptr;
  int              free_ptr;
  logic [BC_W-1:0] buckets;
  out_item_t       expected_q [$];

  assign pending = expected_q.size();

  function automatic out_item_t apply_cmd(in_item_t it);
    out_item_t r;
    int bc, b, cur, prev, last, node, n, steps;
    r = '0;
    r.status = ST_OK;
    if (it.cmd == CMD_NOP) return r;
    bc = buckets;
    if (bc == 0) bc = 1;
    if (bc > MAX_BUCKETS) bc = MAX_BUCKETS;
    b = int'(it.key % 64'(bc));
    cur = head_tbl[b];
    prev = NIL;
    last = NIL;
    node = NIL;
    for (steps = 0; steps < POOL_NODES && cur < NIL; steps++) begin
      if (key_tbl[cur] == it.key) begin
        node = cur;
        break;
      end
      last = cur;
      prev = cur;
      cur = link_tbl[cur];
    end
    if (it.cmd == CMD_SET) begin
      if (node != NIL) begin
        rec_tbl[node] = {it.in_scan, it.in_marked, it.in_size};
        return r;
      end
      if (free_ptr < NIL) begin
        n = free_ptr;
        free_ptr = link_tbl[n];
      end else if (fresh_ptr < POOL_NODES) begin
        n = fresh_ptr;
        fresh_ptr++;
      end else begin
        r.status = ST_FULL;
        return r;
      end
      key_tbl[n] = it.key;
      rec_tbl[n] = {it.in_scan, it.in_marked, it.in_size};
      link_tbl[n] = NIL;
      if (last == NIL) head_tbl[b] = n;
      else link_tbl[last] = n;
      return r;
    end
    if (node == NIL) begin
      r.status = ST_MISS;
      return r;
    end
    if (it.cmd == CMD_GET) begin
      r.out_size   = rec_tbl[node][SIZE_W-1:0];
      r.out_marked = rec_tbl[node][SIZE_W];
      r.out_scan   = rec_tbl[node][SIZE_W+1];
      return r;
    end
    if (prev == NIL) head_tbl[b] = link_tbl[node];
    else link_tbl[prev] = link_tbl[node];
    link_tbl[node] = free_ptr;
    free_ptr = node;
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_item;
    if (!rst_n) begin
      for (int i = 0; i < MAX_BUCKETS; i++) head_tbl[i] = NIL;
      fresh_ptr = 0;
      free_ptr = NIL;
      buckets = BC_RESET;
      expected_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) buckets = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result with nothing expected: %p", $realtime, out_data);
        end else begin
          exp_item = expected_q.pop_front();
          if (out_data !== exp_item) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch exp %p got %p", $realtime, exp_item, out_data);
          end
        end
      end
      if (in_valid && in_ready) expected_q.push_back(apply_cmd(in_data));
    end
  end

endmodule

FILE: sim/tb_chained_hash_map_core.sv
// Testbench top for the chained hash map core: stimulus and verdict.
`timescale 1ns / 100ps
module tb_chained_hash_map_core;
  import chm_pkg::*;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  in_item_t        in_data = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  out_item_t       out_data;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [BC_W-1:0] cfg_data = '0;
  int              fail_count;
  int              pending;
  logic            stim_done = 1'b0;
  int              stall_left = 0;

  // Recently set keys, so that gets and erases often hit live entries.
  logic [KEY_W-1:0] key_pool [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  chained_hash_map_core DUT (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_data
  );

  chm_checker CHK (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_data, .fail_count, .pending
  );

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  // Receiver stall pattern runs from reset to the end.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      stall_left = gap_len();
      out_ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // One input transaction; returns at the accept edge, valid is dropped
  // by the next transaction's gap or by end_input.
  task automatic send_cmd(input cmd_e c, input logic [KEY_W-1:0] k,
                          input logic [SIZE_W-1:0] sz, input logic mk,
                          input logic sc);
    int g;
    g = gap_len();
    @(negedge clk);
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_data <= '{cmd: c, key: k, in_size: sz, in_marked: mk, in_scan: sc};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic end_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Quiesce, then write bucket_count. Results always arrive, so draining
  // the expectation queue leaves the core idle.
  task automatic set_buckets(input logic [BC_W-1:0] bc);
    end_input();
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_data <= bc;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (key_pool.size() != 0 && r < 6)
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (r < 8) return KEY_W'($urandom_range(0, 40));
    return {$urandom, $urandom};
  endfunction

  task automatic random_phase(input int n);
    logic [KEY_W-1:0] k;
    int r;
    cmd_e c;
    for (int i = 0; i < n; i++) begin
      k = pick_key();
      r = $urandom_range(0, 99);
      c = (r < 45) ? CMD_SET : (r < 75) ? CMD_GET : (r < 97) ? CMD_ERASE : CMD_NOP;
      if (c == CMD_SET) begin
        key_pool.push_back(k);
        if (key_pool.size() > 48) void'(key_pool.pop_front());
      end
      send_cmd(c, k, $urandom, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every command, hit/miss, overwrite, chain
    // head/middle unlink with bucket count 1 so all keys share one chain.
    send_cmd(CMD_GET, '1, '1, 1'b1, 1'b1);
    send_cmd(CMD_SET, '1, '1, 1'b1, 1'b1);
    send_cmd(CMD_GET, '1, '0, 1'b0, 1'b0);
    send_cmd(CMD_SET, '0, '0, 1'b0, 1'b0);
    send_cmd(CMD_SET, '1, 32'h5a5a_a5a5, 1'b0, 1'b1);
    send_cmd(CMD_GET, '1, '0, 1'b0, 1'b0);
    send_cmd(CMD_NOP, '1, '1, 1'b1, 1'b1);
    send_cmd(CMD_ERASE, 64'd77, '0, 1'b0, 1'b0);
    send_cmd(CMD_ERASE, '1, '0, 1'b0, 1'b0);
    send_cmd(CMD_GET, '1, '0, 1'b0, 1'b0);
    set_buckets(9'd1);
    for (int i = 1; i <= 4; i++) send_cmd(CMD_SET, KEY_W'(i), 32'(i), 1'b1, 1'b0);
    send_cmd(CMD_ERASE, 64'd2, '0, 1'b0, 1'b0);
    send_cmd(CMD_ERASE, 64'd0, '0, 1'b0, 1'b0);
    send_cmd(CMD_GET, 64'd4, '0, 1'b0, 1'b0);
    send_cmd(CMD_SET, 64'd9, 32'd9, 1'b0, 1'b1);
    send_cmd(CMD_GET, 64'd9, '0, 1'b0, 1'b0);
    set_buckets(9'd0);
    send_cmd(CMD_GET, 64'd3, '0, 1'b0, 1'b0);
    set_buckets(9'd511);
    send_cmd(CMD_GET, 64'd3, '0, 1'b0, 1'b0);

    // Random phases across bucket counts, extremes included.
    set_buckets(9'd256);
    random_phase(200);
    set_buckets(9'd1);
    random_phase(120);
    set_buckets(9'(($urandom_range(2, 255))));
    random_phase(200);
    set_buckets(9'd7);
    random_phase(180);
    set_buckets(9'd256);
    random_phase(150);
    end_input();
    stim_done <= 1'b1;
  end

  initial begin
    @(posedge stim_done);
    while (pending != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (fail_count == 0) $display("PASS chained_hash_map_core");
    else $display("FAIL chained_hash_map_core");
    $finish;
  end

  initial begin
    #200ms;
    $display("FAIL chained_hash_map_core");
    $finish;
  end

endmodule
